// ===== design/swct_pkg.sv =====
package swct_pkg;

    // Fixed-point formats of positions, times and the wall normal
    localparam int FRAC_BITS_DEF     = 16;
    localparam int DIR_FRAC_BITS_DEF = 14;
    localparam int TIME_W            = 48;

    // Near-zero clamp: 1e-12 scaled by 2^EPS_SCALE_BITS
    localparam int EPS_SCALE_BITS = 60;
    localparam int EPS_NUM        = 1152922;
    localparam int EPS_NUM_W      = 21;

    // Configuration register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_WALL_POS_X = 3'd0,
        REG_WALL_POS_Y = 3'd1,
        REG_WALL_POS_Z = 3'd2,
        REG_WALL_DIR_X = 3'd3,
        REG_WALL_DIR_Y = 3'd4,
        REG_WALL_DIR_Z = 3'd5
    } t_reg_idx;

    // Control that travels with each request down the pipeline
    typedef struct packed {
        logic valid;
        logic ev;
    } t_ctl;

endpackage

// ===== design/swct_if.sv =====
interface swct_req_if;
    import swct_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       sphere_x;
    logic signed [31:0]       sphere_y;
    logic signed [31:0]       sphere_z;
    logic signed [31:0]       vel_x;
    logic signed [31:0]       vel_y;
    logic signed [31:0]       vel_z;
    logic [30:0]              radius;
    logic [30:0]              growth_rate;
    logic [TIME_W-1:0]        last_time;
    logic                     in_outside_box;

    modport source (
        output valid, sphere_x, sphere_y, sphere_z, vel_x, vel_y, vel_z,
               radius, growth_rate, last_time, in_outside_box,
        input  ready
    );
    modport sink (
        input  valid, sphere_x, sphere_y, sphere_z, vel_x, vel_y, vel_z,
               radius, growth_rate, last_time, in_outside_box,
        output ready
    );
endinterface

interface swct_rsp_if;
    import swct_pkg::*;
    logic              valid;
    logic              ready;
    logic              event_valid;
    logic [TIME_W-1:0] event_time;
    logic              transfer_kind;

    modport source (
        output valid, event_valid, event_time, transfer_kind,
        input  ready
    );
    modport sink (
        input  valid, event_valid, event_time, transfer_kind,
        output ready
    );
endinterface

// ===== design/swct_dot.sv =====
module swct_dot #(
    parameter int FRAC_BITS     = swct_pkg::FRAC_BITS_DEF,
    parameter int DIR_FRAC_BITS = swct_pkg::DIR_FRAC_BITS_DEF,
    parameter int DW            = 54
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [31:0]            i_sphere_x,
    input  logic signed [31:0]            i_sphere_y,
    input  logic signed [31:0]            i_sphere_z,
    input  logic signed [31:0]            i_vel_x,
    input  logic signed [31:0]            i_vel_y,
    input  logic signed [31:0]            i_vel_z,
    input  logic [30:0]                   i_radius,
    input  logic [30:0]                   i_growth_rate,
    input  logic [swct_pkg::TIME_W-1:0]   i_last_time,
    input  logic                          i_in_outside_box,
    input  logic signed [31:0]            i_wall_pos_x,
    input  logic signed [31:0]            i_wall_pos_y,
    input  logic signed [31:0]            i_wall_pos_z,
    input  logic signed [15:0]            i_wall_dir_x,
    input  logic signed [15:0]            i_wall_dir_y,
    input  logic signed [15:0]            i_wall_dir_z,
    output swct_pkg::t_ctl                o_ctl,
    output logic [DW-1:0]                 o_num,
    output logic [DW-1:0]                 o_den,
    output logic [swct_pkg::TIME_W-1:0]   o_last
);
    import swct_pkg::*;

    localparam int THR_W = 31 + EPS_NUM_W;

    // Stage 1: offsets from the wall point
    t_ctl               r1_ctl;
    logic signed [32:0] r1_dx, r1_dy, r1_dz;
    logic signed [31:0] r1_vx, r1_vy, r1_vz;
    logic [30:0]        r1_rad, r1_grow;
    logic [TIME_W-1:0]  r1_last;
    logic               r1_out;

    // Stage 2: products
    t_ctl               r2_ctl;
    logic signed [48:0] r2_pdx, r2_pdy, r2_pdz;
    logic signed [47:0] r2_pvx, r2_pvy, r2_pvz;
    logic [DW-1:0]      r2_g, r2_r;
    logic [THR_W-1:0]   r2_thr;
    logic [TIME_W-1:0]  r2_last;
    logic               r2_out;

    // Stage 3: sums
    t_ctl               r3_ctl;
    logic signed [DW-1:0] r3_speed, r3_dist;
    logic [THR_W-1:0]   r3_thr;
    logic [TIME_W-1:0]  r3_last;
    logic               r3_out;

    // Stage 4: decision and divider operands
    t_ctl               r4_ctl;
    logic [DW-1:0]      r4_num, r4_den;
    logic [TIME_W-1:0]  r4_last;

    logic signed [48:0] n2_pdx, n2_pdy, n2_pdz;
    logic signed [47:0] n2_pvx, n2_pvy, n2_pvz;
    logic [THR_W-1:0]   n2_thr;
    logic signed [DW-1:0] n3_speed, n3_dist, s_g, s_r;
    logic [DW-1:0]      n4_negd;
    logic               n4_clamp, n4_ev;
    logic signed [DW-1:0] n4_dist;

    always_comb begin
        n2_pdx = r1_dx * i_wall_dir_x;
        n2_pdy = r1_dy * i_wall_dir_y;
        n2_pdz = r1_dz * i_wall_dir_z;
        n2_pvx = r1_vx * i_wall_dir_x;
        n2_pvy = r1_vy * i_wall_dir_y;
        n2_pvz = r1_vz * i_wall_dir_z;
        n2_thr = {{EPS_NUM_W{1'b0}}, r1_rad} * {{31{1'b0}}, EPS_NUM_W'(EPS_NUM)};
    end

    // Sum the dot products and apply the signed radius and growth terms
    always_comb begin
        s_g = $signed(r2_g);
        s_r = $signed(r2_r);
        n3_speed = $signed({{(DW-48){r2_pvx[47]}}, r2_pvx})
                 + $signed({{(DW-48){r2_pvy[47]}}, r2_pvy})
                 + $signed({{(DW-48){r2_pvz[47]}}, r2_pvz})
                 + (r2_out ? s_g : -s_g);
        n3_dist  = $signed({{(DW-49){r2_pdx[48]}}, r2_pdx})
                 + $signed({{(DW-49){r2_pdy[48]}}, r2_pdy})
                 + $signed({{(DW-49){r2_pdz[48]}}, r2_pdz})
                 + (r2_out ? s_r : -s_r);
    end

    // Clamp tiny negative distances of spheres not outside the box and decide whether an event exists
    always_comb begin
        n4_negd  = DW'(-r3_dist);
        n4_clamp = !r3_out && r3_dist < 0 && n4_negd < DW'(r3_thr);
        n4_dist  = n4_clamp ? '0 : r3_dist;
        n4_ev    = r3_speed < 0 && n4_dist >= 0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.valid <= 1'b0;
            r2_ctl.valid <= 1'b0;
            r3_ctl.valid <= 1'b0;
            r4_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r1_ctl.valid <= i_valid;
            r2_ctl.valid <= r1_ctl.valid;
            r3_ctl.valid <= r2_ctl.valid;
            r4_ctl.valid <= r3_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctl.ev <= 1'b0;
            r1_dx     <= {i_sphere_x[31], i_sphere_x} - {i_wall_pos_x[31], i_wall_pos_x};
            r1_dy     <= {i_sphere_y[31], i_sphere_y} - {i_wall_pos_y[31], i_wall_pos_y};
            r1_dz     <= {i_sphere_z[31], i_sphere_z} - {i_wall_pos_z[31], i_wall_pos_z};
            r1_vx     <= i_vel_x;
            r1_vy     <= i_vel_y;
            r1_vz     <= i_vel_z;
            r1_rad    <= i_radius;
            r1_grow   <= i_growth_rate;
            r1_last   <= i_last_time;
            r1_out    <= i_in_outside_box;

            r2_ctl.ev <= r1_ctl.ev;
            r2_pdx    <= n2_pdx;
            r2_pdy    <= n2_pdy;
            r2_pdz    <= n2_pdz;
            r2_pvx    <= n2_pvx;
            r2_pvy    <= n2_pvy;
            r2_pvz    <= n2_pvz;
            r2_g      <= {{(DW-31){1'b0}}, r1_grow} << DIR_FRAC_BITS;
            r2_r      <= {{(DW-31){1'b0}}, r1_rad} << DIR_FRAC_BITS;
            r2_thr    <= n2_thr;
            r2_last   <= r1_last;
            r2_out    <= r1_out;

            r3_ctl.ev <= r2_ctl.ev;
            r3_speed  <= n3_speed;
            r3_dist   <= n3_dist;
            r3_thr    <= r2_thr >> (EPS_SCALE_BITS - DIR_FRAC_BITS);
            r3_last   <= r2_last;
            r3_out    <= r2_out;

            r4_ctl.ev <= n4_ev;
            r4_num    <= n4_ev ? DW'(n4_dist) : '0;
            r4_den    <= n4_ev ? DW'(-r3_speed) : DW'(1);
            r4_last   <= r3_last;
        end
    end

    assign o_ctl  = r4_ctl;
    assign o_num  = r4_num;
    assign o_den  = r4_den;
    assign o_last = r4_last;

endmodule

// ===== design/swct_div.sv =====
module swct_div #(
    parameter int FRAC_BITS = swct_pkg::FRAC_BITS_DEF,
    parameter int DW        = 54
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  swct_pkg::t_ctl                i_ctl,
    input  logic [DW-1:0]                 i_num,
    input  logic [DW-1:0]                 i_den,
    input  logic [swct_pkg::TIME_W-1:0]   i_last,
    output swct_pkg::t_ctl                o_ctl,
    output logic [swct_pkg::TIME_W-1:0]   o_q,
    output logic                          o_sat,
    output logic [swct_pkg::TIME_W-1:0]   o_last
);
    import swct_pkg::*;

    // One quotient bit per stage over the numerator shifted up by FRAC_BITS
    localparam int NW = DW + FRAC_BITS;

    t_ctl              r_ctl  [NW];
    logic [DW-1:0]     r_rem  [NW];
    logic [DW-1:0]     r_num  [NW];
    logic [DW-1:0]     r_den  [NW];
    logic [TIME_W-1:0] r_last [NW];
    logic [TIME_W-1:0] r_q    [NW];
    logic              r_sat  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        localparam int I = NW - 1 - k;
        t_ctl              b_ctl;
        logic [DW-1:0]     b_rem, b_num, b_den;
        logic [TIME_W-1:0] b_last, b_q;
        logic              b_sat, nb, ge;
        logic [DW:0]       t, diff;
        logic [DW-1:0]     n_rem;
        logic [TIME_W-1:0] n_q;
        logic              n_sat;

        if (k == 0) begin : g_first
            assign b_ctl  = i_ctl;
            assign b_rem  = '0;
            assign b_num  = i_num;
            assign b_den  = i_den;
            assign b_last = i_last;
            assign b_q    = '0;
            assign b_sat  = 1'b0;
        end else begin : g_next
            assign b_ctl  = r_ctl[k-1];
            assign b_rem  = r_rem[k-1];
            assign b_num  = r_num[k-1];
            assign b_den  = r_den[k-1];
            assign b_last = r_last[k-1];
            assign b_q    = r_q[k-1];
            assign b_sat  = r_sat[k-1];
        end

        if (I >= FRAC_BITS) begin : g_nbit
            assign nb = b_num[I-FRAC_BITS];
        end else begin : g_zbit
            assign nb = 1'b0;
        end

        // Shift in the next numerator bit, subtract when it fits
        assign t     = {b_rem, nb};
        assign ge    = t >= {1'b0, b_den};
        assign diff  = t - {1'b0, b_den};
        assign n_rem = ge ? diff[DW-1:0] : t[DW-1:0];

        if (I < TIME_W) begin : g_qbit
            assign n_q   = b_q | ({{(TIME_W-1){1'b0}}, ge} << I);
            assign n_sat = b_sat;
        end else begin : g_sbit
            assign n_q   = b_q;
            assign n_sat = b_sat | ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k].valid <= 1'b0;
            end else if (i_en) begin
                r_ctl[k].valid <= b_ctl.valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl[k].ev <= b_ctl.ev;
                r_rem[k]    <= n_rem;
                r_num[k]    <= b_num;
                r_den[k]    <= b_den;
                r_last[k]   <= b_last;
                r_q[k]      <= n_q;
                r_sat[k]    <= n_sat;
            end
        end
    end

    assign o_ctl  = r_ctl[NW-1];
    assign o_q    = r_q[NW-1];
    assign o_sat  = r_sat[NW-1];
    assign o_last = r_last[NW-1];

endmodule

// ===== design/sphere_wall_crossing_time.sv =====
// Sphere / wall crossing-time predictor. Each request carries a growing
// sphere; the block returns one response per request, in order: the absolute
// time (Q32.16, saturating) at which the sphere surface reaches the configured
// wall, or a null event when it moves away or already lies beyond it. One
// request is taken every cycle while the response side keeps up. The pipeline
// runs through the dot-product and decision stages, one restoring-division
// stage per quotient bit (DW being 52 at the default formats), and the final
// add plus output register. A stall on the response side freezes the whole
// pipeline; the wall registers must be written over the APB port only while
// no request is in flight, which the block itself does not enforce.
module sphere_wall_crossing_time #(
    parameter int FRAC_BITS     = swct_pkg::FRAC_BITS_DEF,
    parameter int DIR_FRAC_BITS = swct_pkg::DIR_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swct_req_if.sink    i_req,
    swct_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import swct_pkg::*;

    localparam int DW = ((DIR_FRAC_BITS + 31 > 49) ? DIR_FRAC_BITS + 31 : 49) + 3;

    logic signed [31:0] r_wall_pos_x, r_wall_pos_y, r_wall_pos_z;
    logic signed [15:0] r_wall_dir_x, r_wall_dir_y, r_wall_dir_z;

    logic en;
    t_ctl              dot_ctl, div_ctl;
    logic [DW-1:0]     dot_num, dot_den;
    logic [TIME_W-1:0] dot_last, div_q, div_last;
    logic              div_sat;

    logic              r_out_valid, r_event_valid;
    logic [TIME_W-1:0] r_event_time;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] n_event_time;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_pos_x <= '0;
            r_wall_pos_y <= '0;
            r_wall_pos_z <= '0;
            r_wall_dir_x <= 16'(1 << DIR_FRAC_BITS);
            r_wall_dir_y <= '0;
            r_wall_dir_z <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_WALL_POS_X: r_wall_pos_x <= pwdata;
                REG_WALL_POS_Y: r_wall_pos_y <= pwdata;
                REG_WALL_POS_Z: r_wall_pos_z <= pwdata;
                REG_WALL_DIR_X: r_wall_dir_x <= pwdata[15:0];
                REG_WALL_DIR_Y: r_wall_dir_y <= pwdata[15:0];
                REG_WALL_DIR_Z: r_wall_dir_z <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_WALL_POS_X: prdata = r_wall_pos_x;
            REG_WALL_POS_Y: prdata = r_wall_pos_y;
            REG_WALL_POS_Z: prdata = r_wall_pos_z;
            REG_WALL_DIR_X: prdata = {{16{r_wall_dir_x[15]}}, r_wall_dir_x};
            REG_WALL_DIR_Y: prdata = {{16{r_wall_dir_y[15]}}, r_wall_dir_y};
            REG_WALL_DIR_Z: prdata = {{16{r_wall_dir_z[15]}}, r_wall_dir_z};
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Advance the pipeline whenever the output register can move
    assign en          = !r_out_valid || o_rsp.ready;
    assign i_req.ready = en;

    swct_dot #(
        .FRAC_BITS     (FRAC_BITS),
        .DIR_FRAC_BITS (DIR_FRAC_BITS),
        .DW            (DW)
    ) u_dot (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (i_req.valid),
        .i_sphere_x       (i_req.sphere_x),
        .i_sphere_y       (i_req.sphere_y),
        .i_sphere_z       (i_req.sphere_z),
        .i_vel_x          (i_req.vel_x),
        .i_vel_y          (i_req.vel_y),
        .i_vel_z          (i_req.vel_z),
        .i_radius         (i_req.radius),
        .i_growth_rate    (i_req.growth_rate),
        .i_last_time      (i_req.last_time),
        .i_in_outside_box (i_req.in_outside_box),
        .i_wall_pos_x     (r_wall_pos_x),
        .i_wall_pos_y     (r_wall_pos_y),
        .i_wall_pos_z     (r_wall_pos_z),
        .i_wall_dir_x     (r_wall_dir_x),
        .i_wall_dir_y     (r_wall_dir_y),
        .i_wall_dir_z     (r_wall_dir_z),
        .o_ctl            (dot_ctl),
        .o_num            (dot_num),
        .o_den            (dot_den),
        .o_last           (dot_last)
    );

    swct_div #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (dot_ctl),
        .i_num   (dot_num),
        .i_den   (dot_den),
        .i_last  (dot_last),
        .o_ctl   (div_ctl),
        .o_q     (div_q),
        .o_sat   (div_sat),
        .o_last  (div_last)
    );

    // Add the offset to the last update time and saturate
    always_comb begin
        sum = {1'b0, div_last} + {1'b0, div_q};
        if (!div_ctl.ev) begin
            n_event_time = '0;
        end else if (div_sat || sum[TIME_W]) begin
            n_event_time = '1;
        end else begin
            n_event_time = sum[TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_event_valid <= div_ctl.ev;
            r_event_time  <= n_event_time;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.event_valid   = r_event_valid;
    assign o_rsp.event_time    = r_event_time;
    assign o_rsp.transfer_kind = 1'b1;

endmodule

// ===== design/swct_checker.sv =====
module swct_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_event_valid,
    input logic [47:0] i_event_time,
    input logic        i_transfer_kind
);

    // Hold a stalled response
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped while stalled");

    // Take requests exactly when the output register can move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (i_out_ready || !i_out_valid))
        else $error("request ready does not follow output side");

    // Null events carry zero time
    a_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_event_valid |-> i_event_time == 48'd0)
        else $error("null event with nonzero time");

    // Every response is a wall transfer
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_transfer_kind)
        else $error("transfer kind not set");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

endmodule

bind sphere_wall_crossing_time swct_sva u_swct_sva (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_event_valid   (o_rsp.event_valid),
    .i_event_time    (o_rsp.event_time),
    .i_transfer_kind (o_rsp.transfer_kind)
);
